// File: rtl/kdm_pkg.sv
// shared types, constants and helpers for the median-split 3-d tree builder
package kdm_pkg;

    localparam int MAX_POINTS  = 64;
    localparam int COORD_W     = 32;
    localparam int NUM_AXES    = 3;
    localparam int IDX_W       = $clog2(MAX_POINTS);
    localparam int CNT_W       = IDX_W + 1;
    localparam int SLOT_W      = 7;
    localparam int AXIS_W      = 2;
    localparam int STACK_DEPTH = 8;
    localparam int SP_W        = $clog2(STACK_DEPTH);
    localparam int TOP_W       = SP_W + 1;

    typedef logic [AXIS_W-1:0] axis_t;
    localparam axis_t AXIS_X = 2'd0;
    localparam axis_t AXIS_Y = 2'd1;
    localparam axis_t AXIS_Z = 2'd2;

    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [CNT_W-1:0] cnt_t;
    typedef logic [SLOT_W-1:0] slot_t;
    typedef logic [NUM_AXES-1:0][COORD_W-1:0] pt_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] x_coord;
        logic signed [COORD_W-1:0] y_coord;
        logic signed [COORD_W-1:0] z_coord;
        logic                      last_point;
    } in_t;

    typedef struct packed {
        logic [6:0]                node_slot;
        logic [5:0]                point_id;
        logic signed [COORD_W-1:0] node_x;
        logic signed [COORD_W-1:0] node_y;
        logic signed [COORD_W-1:0] node_z;
        logic                      has_left;
        logic                      has_right;
        logic                      last_node;
    } out_t;

    typedef struct packed {
        slot_t slot;
        idx_t  lo;
        idx_t  hi;
        axis_t axis;
    } rng_t;

    typedef enum logic [5:0] {
        ST_IDLE, ST_SORT_ROW, ST_SORT_RUN, ST_SORT_DRAIN, ST_SORT_WR,
        ST_BLD_ROOT, ST_POP, ST_MED_RD, ST_MED_CAP, ST_MED_PT,
        ST_EM_LEAF, ST_EM_ONE, ST_EM_TWO,
        ST_AL_RD, ST_AL_CAP, ST_AL_PT, ST_AL_EM,
        ST_AR_RD, ST_AR_CAP, ST_AR_PT, ST_AR_EM,
        ST_SPLIT_INIT, ST_SC_START, ST_SC_RD, ST_SC_CAP, ST_SC_PT, ST_SC_WR,
        ST_SC_MED, ST_CP_RD, ST_CP_WR, ST_SP_NEXT, ST_SP_EMIT,
        ST_PUSH_R, ST_PUSH_L, ST_FINISH
    } state_t;

    typedef enum logic [1:0] {LA_MID, LA_LO, LA_HI, LA_SCAN} laddr_t;
    typedef enum logic [1:0] {CAP_NONE, CAP_MED, CAP_AUX_AXIS, CAP_AUX_WHICH} cap_t;
    typedef enum logic [2:0] {EM_NONE, EM_LEAF, EM_MED_L, EM_MED_LR, EM_LEFT, EM_RIGHT} emit_t;

    typedef struct packed {
        logic   load;
        logic   sorting;
        logic   sort_start;
        logic   sort_row;
        logic   sort_step;
        logic   sort_write;
        logic   push_root;
        logic   pop;
        laddr_t laddr;
        cap_t   cap;
        emit_t  emit;
        logic   split_init;
        logic   split_next;
        logic   scan_init;
        logic   scan_write;
        logic   med_write;
        logic   copy_write;
        logic   push_right;
        logic   push_left;
        logic   finish;
    } cmd_t;

    typedef struct packed {
        logic i_last;
        logic j_last;
        logic stack_empty;
        logic span0;
        logic span1;
        logic span2;
        logic scan_last;
        logic copy_last;
        logic split_last;
        logic emit_ok;
        logic out_free;
    } sts_t;

    function automatic axis_t axis_inc(input axis_t a);
        axis_t r;
        case (a)
            AXIS_X:  r = AXIS_Y;
            AXIS_Y:  r = AXIS_Z;
            default: r = AXIS_X;
        endcase
        return r;
    endfunction

    function automatic logic signed [COORD_W-1:0] coord_of(input pt_t p, input axis_t a);
        logic signed [COORD_W-1:0] r;
        case (a)
            AXIS_X:  r = $signed(p[0]);
            AXIS_Y:  r = $signed(p[1]);
            default: r = $signed(p[2]);
        endcase
        return r;
    endfunction

    // order by coordinate, then by load index
    function automatic logic key_less(input logic signed [COORD_W-1:0] a,
                                      input logic signed [COORD_W-1:0] b,
                                      input idx_t ia, input idx_t ib);
        return (a < b) || ((a == b) && (ia < ib));
    endfunction

endpackage

// File: rtl/kdm_ctrl.sv
// sequencer for loading, sorting and tree construction
module kdm_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    input  logic            last_point,
    output logic            s_ready,
    input  kdm_pkg::sts_t   sts,
    output kdm_pkg::cmd_t   cmd
);

    kdm_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= kdm_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            kdm_pkg::ST_IDLE: begin
                if (s_valid && last_point) state_next = kdm_pkg::ST_SORT_ROW;
            end
            kdm_pkg::ST_SORT_ROW:   state_next = kdm_pkg::ST_SORT_RUN;
            kdm_pkg::ST_SORT_RUN: begin
                if (sts.j_last) state_next = kdm_pkg::ST_SORT_DRAIN;
            end
            kdm_pkg::ST_SORT_DRAIN: state_next = kdm_pkg::ST_SORT_WR;
            kdm_pkg::ST_SORT_WR: begin
                state_next = sts.i_last ? kdm_pkg::ST_BLD_ROOT : kdm_pkg::ST_SORT_ROW;
            end
            kdm_pkg::ST_BLD_ROOT:   state_next = kdm_pkg::ST_POP;
            kdm_pkg::ST_POP: begin
                state_next = sts.stack_empty ? kdm_pkg::ST_FINISH : kdm_pkg::ST_MED_RD;
            end
            kdm_pkg::ST_MED_RD:     state_next = kdm_pkg::ST_MED_CAP;
            kdm_pkg::ST_MED_CAP:    state_next = kdm_pkg::ST_MED_PT;
            kdm_pkg::ST_MED_PT: begin
                if (sts.span0)      state_next = kdm_pkg::ST_EM_LEAF;
                else if (sts.span1) state_next = kdm_pkg::ST_EM_ONE;
                else if (sts.span2) state_next = kdm_pkg::ST_EM_TWO;
                else                state_next = kdm_pkg::ST_SPLIT_INIT;
            end
            kdm_pkg::ST_EM_LEAF: begin
                if (sts.emit_ok) state_next = kdm_pkg::ST_POP;
            end
            kdm_pkg::ST_EM_ONE, kdm_pkg::ST_EM_TWO: begin
                if (sts.emit_ok) state_next = kdm_pkg::ST_AL_RD;
            end
            kdm_pkg::ST_AL_RD:  state_next = kdm_pkg::ST_AL_CAP;
            kdm_pkg::ST_AL_CAP: state_next = kdm_pkg::ST_AL_PT;
            kdm_pkg::ST_AL_PT:  state_next = kdm_pkg::ST_AL_EM;
            kdm_pkg::ST_AL_EM: begin
                if (sts.emit_ok) state_next = sts.span2 ? kdm_pkg::ST_AR_RD : kdm_pkg::ST_POP;
            end
            kdm_pkg::ST_AR_RD:  state_next = kdm_pkg::ST_AR_CAP;
            kdm_pkg::ST_AR_CAP: state_next = kdm_pkg::ST_AR_PT;
            kdm_pkg::ST_AR_PT:  state_next = kdm_pkg::ST_AR_EM;
            kdm_pkg::ST_AR_EM: begin
                if (sts.emit_ok) state_next = kdm_pkg::ST_POP;
            end
            kdm_pkg::ST_SPLIT_INIT: state_next = kdm_pkg::ST_SC_START;
            kdm_pkg::ST_SC_START:   state_next = kdm_pkg::ST_SC_RD;
            kdm_pkg::ST_SC_RD:      state_next = kdm_pkg::ST_SC_CAP;
            kdm_pkg::ST_SC_CAP:     state_next = kdm_pkg::ST_SC_PT;
            kdm_pkg::ST_SC_PT:      state_next = kdm_pkg::ST_SC_WR;
            kdm_pkg::ST_SC_WR: begin
                state_next = sts.scan_last ? kdm_pkg::ST_SC_MED : kdm_pkg::ST_SC_RD;
            end
            kdm_pkg::ST_SC_MED:     state_next = kdm_pkg::ST_CP_RD;
            kdm_pkg::ST_CP_RD:      state_next = kdm_pkg::ST_CP_WR;
            kdm_pkg::ST_CP_WR: begin
                if (!sts.copy_last)     state_next = kdm_pkg::ST_CP_RD;
                else if (sts.split_last) state_next = kdm_pkg::ST_SP_EMIT;
                else                    state_next = kdm_pkg::ST_SP_NEXT;
            end
            kdm_pkg::ST_SP_NEXT:    state_next = kdm_pkg::ST_SC_START;
            kdm_pkg::ST_SP_EMIT: begin
                if (sts.emit_ok) state_next = kdm_pkg::ST_PUSH_R;
            end
            kdm_pkg::ST_PUSH_R:     state_next = kdm_pkg::ST_PUSH_L;
            kdm_pkg::ST_PUSH_L:     state_next = kdm_pkg::ST_POP;
            kdm_pkg::ST_FINISH: begin
                if (sts.out_free) state_next = kdm_pkg::ST_IDLE;
            end
            default: state_next = kdm_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        case (state_reg)
            kdm_pkg::ST_IDLE: begin
                s_ready        = 1'b1;
                cmd.load       = s_valid;
                cmd.sort_start = 1'b1;
            end
            kdm_pkg::ST_SORT_ROW: begin
                cmd.sorting  = 1'b1;
                cmd.sort_row = 1'b1;
            end
            kdm_pkg::ST_SORT_RUN: begin
                cmd.sorting   = 1'b1;
                cmd.sort_step = 1'b1;
            end
            kdm_pkg::ST_SORT_DRAIN: cmd.sorting = 1'b1;
            kdm_pkg::ST_SORT_WR: begin
                cmd.sorting    = 1'b1;
                cmd.sort_write = 1'b1;
            end
            kdm_pkg::ST_BLD_ROOT:   cmd.push_root = 1'b1;
            kdm_pkg::ST_POP:        cmd.pop = !sts.stack_empty;
            kdm_pkg::ST_MED_RD:     cmd.laddr = kdm_pkg::LA_MID;
            kdm_pkg::ST_MED_CAP:    cmd.cap = kdm_pkg::CAP_MED;
            kdm_pkg::ST_EM_LEAF:    cmd.emit = kdm_pkg::EM_LEAF;
            kdm_pkg::ST_EM_ONE:     cmd.emit = kdm_pkg::EM_MED_L;
            kdm_pkg::ST_EM_TWO:     cmd.emit = kdm_pkg::EM_MED_LR;
            kdm_pkg::ST_AL_RD:      cmd.laddr = kdm_pkg::LA_LO;
            kdm_pkg::ST_AL_CAP:     cmd.cap = kdm_pkg::CAP_AUX_AXIS;
            kdm_pkg::ST_AL_EM:      cmd.emit = kdm_pkg::EM_LEFT;
            kdm_pkg::ST_AR_RD:      cmd.laddr = kdm_pkg::LA_HI;
            kdm_pkg::ST_AR_CAP:     cmd.cap = kdm_pkg::CAP_AUX_AXIS;
            kdm_pkg::ST_AR_EM:      cmd.emit = kdm_pkg::EM_RIGHT;
            kdm_pkg::ST_SPLIT_INIT: cmd.split_init = 1'b1;
            kdm_pkg::ST_SC_START:   cmd.scan_init = 1'b1;
            kdm_pkg::ST_SC_RD:      cmd.laddr = kdm_pkg::LA_SCAN;
            kdm_pkg::ST_SC_CAP:     cmd.cap = kdm_pkg::CAP_AUX_WHICH;
            kdm_pkg::ST_SC_WR:      cmd.scan_write = 1'b1;
            kdm_pkg::ST_SC_MED:     cmd.med_write = 1'b1;
            kdm_pkg::ST_CP_WR:      cmd.copy_write = 1'b1;
            kdm_pkg::ST_SP_NEXT:    cmd.split_next = 1'b1;
            kdm_pkg::ST_SP_EMIT:    cmd.emit = kdm_pkg::EM_MED_LR;
            kdm_pkg::ST_PUSH_R:     cmd.push_right = 1'b1;
            kdm_pkg::ST_PUSH_L:     cmd.push_left = 1'b1;
            kdm_pkg::ST_FINISH:     cmd.finish = 1'b1;
            default: ;
        endcase
    end

endmodule

// File: rtl/kdm_dp.sv
// datapath: point store, axis lists, scratch list, range stack and result registers
module kdm_dp (
    input  logic           aclk,
    input  logic           aresetn,
    input  kdm_pkg::in_t   s_data,
    input  kdm_pkg::cmd_t  cmd,
    output kdm_pkg::sts_t  sts,
    output logic           m_valid,
    input  logic           m_ready,
    output kdm_pkg::out_t  m_data
);

    // memories
    kdm_pkg::pt_t  pts_mem [kdm_pkg::MAX_POINTS];
    kdm_pkg::idx_t lst_mem [kdm_pkg::NUM_AXES][kdm_pkg::MAX_POINTS];
    kdm_pkg::idx_t scr_mem [kdm_pkg::MAX_POINTS];

    kdm_pkg::pt_t  pa_reg, pb_reg;
    kdm_pkg::idx_t lq_reg [kdm_pkg::NUM_AXES];
    kdm_pkg::idx_t sq_reg;

    kdm_pkg::cnt_t  cnt_reg;
    kdm_pkg::idx_t  n_m1_reg;
    kdm_pkg::idx_t  i_reg, j_reg, jd_reg;
    logic           cmpv_reg;
    kdm_pkg::idx_t  rank_reg [kdm_pkg::NUM_AXES];

    kdm_pkg::rng_t  cur_reg;
    kdm_pkg::rng_t  stk_reg [kdm_pkg::STACK_DEPTH];
    logic [kdm_pkg::TOP_W-1:0] top_reg;
    kdm_pkg::idx_t  med_id_reg, aux_reg;
    kdm_pkg::axis_t which_reg;
    kdm_pkg::idx_t  sidx_reg, nl_reg, nr_reg, k_reg;

    kdm_pkg::out_t  hold_reg, out_reg;
    logic           hold_valid_reg, out_valid_reg;

    kdm_pkg::idx_t  ra, rb, laddr, mid, span, lq_axis, lq_which;
    kdm_pkg::cnt_t  mid_sum;
    logic [kdm_pkg::TOP_W-1:0] top_dec;
    logic           lst_we [kdm_pkg::NUM_AXES];
    kdm_pkg::idx_t  lst_wa [kdm_pkg::NUM_AXES];
    kdm_pkg::idx_t  lst_wd [kdm_pkg::NUM_AXES];
    logic           scr_we;
    kdm_pkg::idx_t  scr_wa, scr_wd;
    kdm_pkg::out_t  node, fin_node;
    kdm_pkg::pt_t   node_pt;
    logic           emit_fire, fin_fire, out_free, scan_less, stored;
    kdm_pkg::axis_t nxt_axis;
    kdm_pkg::slot_t slot_l, slot_r;

    assign mid_sum  = {1'b0, cur_reg.lo} + {1'b0, cur_reg.hi} + kdm_pkg::cnt_t'(1);
    assign mid      = mid_sum[kdm_pkg::CNT_W-1:1];
    assign span     = cur_reg.hi - cur_reg.lo;
    assign top_dec  = top_reg - 1'b1;
    assign nxt_axis = kdm_pkg::axis_inc(cur_reg.axis);
    assign slot_l   = {cur_reg.slot[kdm_pkg::SLOT_W-2:0], 1'b0};
    assign slot_r   = {cur_reg.slot[kdm_pkg::SLOT_W-2:0], 1'b1};
    assign out_free = !out_valid_reg || m_ready;
    assign stored   = cnt_reg < kdm_pkg::cnt_t'(kdm_pkg::MAX_POINTS);

    assign ra = cmd.sorting ? i_reg : med_id_reg;
    assign rb = cmd.sorting ? j_reg : aux_reg;

    always_comb begin
        case (cmd.laddr)
            kdm_pkg::LA_LO:   laddr = cur_reg.lo;
            kdm_pkg::LA_HI:   laddr = cur_reg.hi;
            kdm_pkg::LA_SCAN: laddr = sidx_reg;
            default:          laddr = mid;
        endcase
        case (cur_reg.axis)
            kdm_pkg::AXIS_X: lq_axis = lq_reg[0];
            kdm_pkg::AXIS_Y: lq_axis = lq_reg[1];
            default:         lq_axis = lq_reg[2];
        endcase
        case (which_reg)
            kdm_pkg::AXIS_X: lq_which = lq_reg[0];
            kdm_pkg::AXIS_Y: lq_which = lq_reg[1];
            default:         lq_which = lq_reg[2];
        endcase
    end

    // point store
    always_ff @(posedge aclk) begin
        if (cmd.load && stored) begin
            pts_mem[cnt_reg[kdm_pkg::IDX_W-1:0]] <=
                {s_data.z_coord, s_data.y_coord, s_data.x_coord};
        end
        pa_reg <= pts_mem[ra];
        pb_reg <= pts_mem[rb];
    end

    // axis list writes: sort places by rank, copy-back restores a split range
    always_comb begin
        for (int w = 0; w < kdm_pkg::NUM_AXES; w++) begin
            lst_we[w] = 1'b0;
            lst_wa[w] = rank_reg[w];
            lst_wd[w] = i_reg;
            if (cmd.sort_write) begin
                lst_we[w] = 1'b1;
            end else if (cmd.copy_write && which_reg == kdm_pkg::axis_t'(w)) begin
                lst_we[w] = 1'b1;
                lst_wa[w] = cur_reg.lo + k_reg;
                lst_wd[w] = sq_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int w = 0; w < kdm_pkg::NUM_AXES; w++) begin
            if (lst_we[w]) lst_mem[w][lst_wa[w]] <= lst_wd[w];
            lq_reg[w] <= lst_mem[w][laddr];
        end
    end

    // scratch list
    assign scan_less = kdm_pkg::key_less(kdm_pkg::coord_of(pb_reg, cur_reg.axis),
                                         kdm_pkg::coord_of(pa_reg, cur_reg.axis),
                                         aux_reg, med_id_reg);

    always_comb begin
        scr_we = 1'b0;
        scr_wa = nl_reg;
        scr_wd = aux_reg;
        if (cmd.scan_write && aux_reg != med_id_reg) begin
            scr_we = 1'b1;
            scr_wa = scan_less ? nl_reg : nr_reg;
        end else if (cmd.med_write) begin
            scr_we = 1'b1;
            scr_wa = mid - cur_reg.lo;
            scr_wd = med_id_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (scr_we) scr_mem[scr_wa] <= scr_wd;
        sq_reg <= scr_mem[k_reg];
    end

    // load count and sort counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            cmpv_reg <= 1'b0;
        end else begin
            cmpv_reg <= cmd.sort_step;
            if (cmd.load) begin
                if (s_data.last_point) begin
                    cnt_reg <= '0;
                end else if (stored) begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load && s_data.last_point) begin
            // n is at least one here, so n-1 fits the index width
            n_m1_reg <= stored ? cnt_reg[kdm_pkg::IDX_W-1:0]
                               : kdm_pkg::idx_t'(kdm_pkg::MAX_POINTS - 1);
        end
        if (cmd.sort_start) i_reg <= '0;
        else if (cmd.sort_write) i_reg <= i_reg + 1'b1;
        if (cmd.sort_row) j_reg <= '0;
        else if (cmd.sort_step) j_reg <= j_reg + 1'b1;
        jd_reg <= j_reg;
        for (int w = 0; w < kdm_pkg::NUM_AXES; w++) begin
            if (cmd.sort_row) begin
                rank_reg[w] <= '0;
            end else if (cmpv_reg && kdm_pkg::key_less(
                         kdm_pkg::coord_of(pb_reg, kdm_pkg::axis_t'(w)),
                         kdm_pkg::coord_of(pa_reg, kdm_pkg::axis_t'(w)),
                         jd_reg, i_reg)) begin
                rank_reg[w] <= rank_reg[w] + 1'b1;
            end
        end
    end

    // range stack; pushes beyond the depth are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            top_reg <= '0;
        end else begin
            if (cmd.push_root) begin
                stk_reg[0] <= '{slot: kdm_pkg::slot_t'(1), lo: '0, hi: n_m1_reg,
                                axis: kdm_pkg::AXIS_X};
                top_reg    <= kdm_pkg::TOP_W'(1);
            end else if (cmd.pop) begin
                top_reg <= top_dec;
            end else if ((cmd.push_right || cmd.push_left) &&
                         top_reg < kdm_pkg::TOP_W'(kdm_pkg::STACK_DEPTH)) begin
                if (cmd.push_right) begin
                    stk_reg[top_reg[kdm_pkg::SP_W-1:0]] <=
                        '{slot: slot_r, lo: mid + 1'b1, hi: cur_reg.hi, axis: nxt_axis};
                end else begin
                    stk_reg[top_reg[kdm_pkg::SP_W-1:0]] <=
                        '{slot: slot_l, lo: cur_reg.lo, hi: mid - 1'b1, axis: nxt_axis};
                end
                top_reg <= top_reg + 1'b1;
            end
        end
    end

    // current range, median, scan and copy counters
    always_ff @(posedge aclk) begin
        if (cmd.pop) cur_reg <= stk_reg[top_dec[kdm_pkg::SP_W-1:0]];
        case (cmd.cap)
            kdm_pkg::CAP_MED:       med_id_reg <= lq_axis;
            kdm_pkg::CAP_AUX_AXIS:  aux_reg <= lq_axis;
            kdm_pkg::CAP_AUX_WHICH: aux_reg <= lq_which;
            default: ;
        endcase
        if (cmd.split_init) which_reg <= nxt_axis;
        else if (cmd.split_next) which_reg <= kdm_pkg::axis_inc(which_reg);
        if (cmd.scan_init) begin
            sidx_reg <= cur_reg.lo;
            nl_reg   <= '0;
            nr_reg   <= mid - cur_reg.lo + 1'b1;
        end else if (cmd.scan_write) begin
            sidx_reg <= sidx_reg + 1'b1;
            if (aux_reg != med_id_reg) begin
                if (scan_less) nl_reg <= nl_reg + 1'b1;
                else           nr_reg <= nr_reg + 1'b1;
            end
        end
        if (cmd.med_write) k_reg <= '0;
        else if (cmd.copy_write) k_reg <= k_reg + 1'b1;
    end

    // node assembly
    always_comb begin
        node           = '0;
        node_pt        = pa_reg;
        node.node_slot = cur_reg.slot;
        node.point_id  = med_id_reg;
        case (cmd.emit)
            kdm_pkg::EM_MED_L:  node.has_left = 1'b1;
            kdm_pkg::EM_MED_LR: begin
                node.has_left  = 1'b1;
                node.has_right = 1'b1;
            end
            kdm_pkg::EM_LEFT: begin
                node.node_slot = slot_l;
                node.point_id  = aux_reg;
                node_pt        = pb_reg;
            end
            kdm_pkg::EM_RIGHT: begin
                node.node_slot = slot_r;
                node.point_id  = aux_reg;
                node_pt        = pb_reg;
            end
            default: ;
        endcase
        node.node_x = $signed(node_pt[0]);
        node.node_y = $signed(node_pt[1]);
        node.node_z = $signed(node_pt[2]);
    end

    always_comb begin
        fin_node           = hold_reg;
        fin_node.last_node = 1'b1;
    end

    // one node is held back until it is known whether it ends the tree
    assign emit_fire = (cmd.emit != kdm_pkg::EM_NONE) && (!hold_valid_reg || out_free);
    assign fin_fire  = cmd.finish && out_free && hold_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (emit_fire) hold_valid_reg <= 1'b1;
            else if (fin_fire) hold_valid_reg <= 1'b0;
            if ((emit_fire && hold_valid_reg) || fin_fire) out_valid_reg <= 1'b1;
            else if (m_ready) out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit_fire) begin
            hold_reg <= node;
            if (hold_valid_reg) out_reg <= hold_reg;
        end else if (fin_fire) begin
            out_reg <= fin_node;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    always_comb begin
        sts             = '0;
        sts.i_last      = i_reg == n_m1_reg;
        sts.j_last      = j_reg == n_m1_reg;
        sts.stack_empty = top_reg == '0;
        sts.span0       = span == kdm_pkg::idx_t'(0);
        sts.span1       = span == kdm_pkg::idx_t'(1);
        sts.span2       = span == kdm_pkg::idx_t'(2);
        sts.scan_last   = sidx_reg == cur_reg.hi;
        sts.copy_last   = k_reg == span;
        sts.split_last  = kdm_pkg::axis_inc(which_reg) == cur_reg.axis;
        sts.emit_ok     = !hold_valid_reg || out_free;
        sts.out_free    = out_free;
    end

endmodule

// File: rtl/kd_tree_median_build.sv
// Median-split 3-d tree builder. Points load one per cycle while the block is idle; the
// transfer marked last_point stores its point and starts the build, during which s_ready is
// low. The build first ranks all n points on x, y and z together, one point pair per cycle
// through the point store's two read ports. Each node of four or more points then
// partitions the two other axis lists point by point over its range (scan, then copy
// back from the scratch list), and each node also needs a median look-up. Nodes leave
// in preorder on the m_ channel, one per point, with last_node on the final one; the
// output register lets the builder run ahead by one node while a transfer is stalled.
module kd_tree_median_build (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  kdm_pkg::in_t   s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output kdm_pkg::out_t  m_data
);

    kdm_pkg::cmd_t cmd;
    kdm_pkg::sts_t sts;

    kdm_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .last_point (s_data.last_point),
        .s_ready    (s_ready),
        .sts        (sts),
        .cmd        (cmd)
    );

    kdm_dp u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .sts     (sts),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule
